// File: sv/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros used by the checker file of the record encoder.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define IHRE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also runs during reset.
`define IHRE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: sv/ihre_pkg.sv
// ============================================================================
// ihre_pkg
// Types, constants and character helpers of the Intel HEX record encoder.
// ============================================================================
package ihre_pkg;

  // Data bytes gathered into one data record.
  localparam int REC_BYTES = 16;
  localparam int FILL_W    = $clog2(REC_BYTES + 1);
  localparam int ADDR_W    = (REC_BYTES > 1) ? $clog2(REC_BYTES) : 1;

  localparam int BYTE_W = 8;
  localparam int CHAR_W = 7;
  localparam int IDX_W  = 4;

  localparam logic [CHAR_W-1:0] CHR_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CHR_NL    = 7'h0A;
  localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHR_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CHR_TWO   = 7'h32;
  localparam logic [CHAR_W-1:0] CHR_FOUR  = 7'h34;
  localparam logic [CHAR_W-1:0] CHR_F     = 7'h46;

  // Byte count plus record type of an extended linear address record.
  localparam logic [7:0] SEG_HDR_SUM = 8'h06;

  // Last character position of each record part.
  localparam logic [IDX_W-1:0] SEG_LAST  = 4'd15;
  localparam logic [IDX_W-1:0] HDR_LAST  = 4'd8;
  localparam logic [IDX_W-1:0] TAIL_LAST = 4'd2;
  localparam logic [IDX_W-1:0] EOF_LAST  = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_DHDR,
    ST_DHI,
    ST_DLO,
    ST_DTAIL,
    ST_EOF
  } ihre_state_t;

  // Upper-case hex digit of one nibble.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CHR_ZERO + CHAR_W'(nib);
    end else begin
      return 7'h37 + CHAR_W'(nib);
    end
  endfunction

  // Fixed text ":02000004" that opens an extended linear address record.
  function automatic logic [CHAR_W-1:0] seg_prefix_char(input logic [IDX_W-1:0] idx);
    case (idx) inside
      4'd0:          return CHR_COLON;
      4'd2:          return CHR_TWO;
      4'd8:          return CHR_FOUR;
      4'd1, [4'd3:4'd7]: return CHR_ZERO;
      default:       return CHR_ZERO;
    endcase
  endfunction

  // Fixed text ":00000001FF" of the end-of-file record.
  function automatic logic [CHAR_W-1:0] eof_char(input logic [IDX_W-1:0] idx);
    case (idx) inside
      4'd0:          return CHR_COLON;
      4'd8:          return CHR_ONE;
      [4'd9:4'd10]:  return CHR_F;
      [4'd1:4'd7]:   return CHR_ZERO;
      default:       return CHR_NL;
    endcase
  endfunction

endpackage

// File: sv/ihre_ram.sv
// ============================================================================
// ihre_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module ihre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/intel_hex_record_encoder_unit.sv
// ============================================================================
// intel_hex_record_encoder_unit
// Turns a byte stream into Intel HEX text, one ASCII character per transfer.
// ============================================================================
// Usage: image bytes arrive on the in_ channel in address order from zero,
// the final one flagged by in_is_last. The out_ channel delivers the record
// text one character per transfer; out_run_last marks the final character
// caused by an input byte and out_image_done the newline of the end-of-file
// record. The input transfer of a byte opens the records it closes: an
// extended linear address record (16 characters) at each 64 KiB segment
// start, a data record (12 + 2*count characters) when the buffer fills, the
// segment ends or the last byte comes, and the end-of-file record
// (12 characters) after the last byte. Once a byte opens records, the
// sequencer loads its first character into the output register; then
// one character leaves per cycle while out_stall is low. in_stall stays
// high until the final character has been handed to the output register.
// The character rate is set by the single output register and by the
// record buffer RAM, which is read one byte per two characters. A byte
// that closes no record leaves the sequencer idle and gives no transfer.
// A stalled receiver simply freezes the sequencer; nothing is lost.
// Synchronous reset returns the block to the start of an empty image and
// empties the output register.
// ============================================================================
module intel_hex_record_encoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ihre_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic                         in_is_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ihre_pkg::CHAR_W-1:0]  out_ascii_char,
  output logic                         out_run_last,
  output logic                         out_image_done,
  output logic                         out_overflow
);

  import ihre_pkg::*;

  // Sequencer state and character position within the current record part.
  ihre_state_t         state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [FILL_W-1:0]   bidx_r, bidx_nxt;
  logic [BYTE_W-1:0]   byte_r, byte_nxt;

  // Running image state.
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [15:0]         off_r, off_nxt;
  logic [15:0]         seg_r, seg_nxt;
  logic [7:0]          csum_r, csum_nxt;
  logic                ovf_r, ovf_nxt;
  logic                full_r, full_nxt;

  // Snapshot of the records that the accepted byte produces.
  logic [FILL_W-1:0]   rec_cnt_r, rec_cnt_nxt;
  logic [15:0]         rec_off_r, rec_off_nxt;
  logic [15:0]         rec_seg_r, rec_seg_nxt;
  logic [7:0]          rec_ck_r, rec_ck_nxt;
  logic [7:0]          seg_ck_r, seg_ck_nxt;
  logic                do_data_r, do_data_nxt;
  logic                do_eof_r, do_eof_nxt;
  logic                emit_ovf_r, emit_ovf_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_rl_r, out_rl_nxt;
  logic                out_done_r, out_done_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // Record buffer RAM ports.
  logic                ram_we;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;

  logic                in_accept;
  logic                emit_ok;
  logic [FILL_W-1:0]   fill_inc;
  logic [16:0]         off_sum;
  logic                close;
  logic                seg_start;
  logic [7:0]          csum_new;
  logic [7:0]          cnt8;
  logic [7:0]          rec_cnt8;
  logic [7:0]          data_ck;
  logic [7:0]          seg_ck;
  logic [CHAR_W-1:0]   char_c;
  logic                rl_c;
  logic                done_c;
  logic                emit;

  ihre_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (REC_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[ADDR_W-1:0]),
    .wdata (in_data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The block takes a byte only while the sequencer is idle.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  // A new character may enter the output register when it is empty or drains.
  assign emit_ok   = !out_valid_r || !out_stall;

  // Record bookkeeping for the byte on the input.
  assign fill_inc  = fill_r + FILL_W'(1);
  assign off_sum   = {1'b0, off_r} + 17'(fill_inc);
  assign close     = (fill_inc == FILL_W'(REC_BYTES)) || off_sum[16] || in_is_last;
  assign seg_start = (fill_r == '0) && (off_r == '0);
  assign csum_new  = csum_r + in_data_byte;
  assign cnt8      = 8'(fill_inc);
  assign data_ck   = 8'h00 - (cnt8 + off_r[15:8] + off_r[7:0] + csum_new);
  assign seg_ck    = 8'h00 - (SEG_HDR_SUM + seg_r[15:8] + seg_r[7:0]);
  // Byte count field of the data record being sent.
  assign rec_cnt8  = 8'(rec_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      bidx_r      <= '0;
      fill_r      <= '0;
      off_r       <= '0;
      seg_r       <= '0;
      csum_r      <= '0;
      ovf_r       <= 1'b0;
      full_r      <= 1'b0;
      do_data_r   <= 1'b0;
      do_eof_r    <= 1'b0;
      emit_ovf_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      bidx_r      <= bidx_nxt;
      fill_r      <= fill_nxt;
      off_r       <= off_nxt;
      seg_r       <= seg_nxt;
      csum_r      <= csum_nxt;
      ovf_r       <= ovf_nxt;
      full_r      <= full_nxt;
      do_data_r   <= do_data_nxt;
      do_eof_r    <= do_eof_nxt;
      emit_ovf_r  <= emit_ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    rec_cnt_r  <= rec_cnt_nxt;
    rec_off_r  <= rec_off_nxt;
    rec_seg_r  <= rec_seg_nxt;
    rec_ck_r   <= rec_ck_nxt;
    seg_ck_r   <= seg_ck_nxt;
    out_char_r <= out_char_nxt;
    out_rl_r   <= out_rl_nxt;
    out_done_r <= out_done_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    bidx_nxt     = bidx_r;
    byte_nxt     = byte_r;
    fill_nxt     = fill_r;
    off_nxt      = off_r;
    seg_nxt      = seg_r;
    csum_nxt     = csum_r;
    ovf_nxt      = ovf_r;
    full_nxt     = full_r;
    rec_cnt_nxt  = rec_cnt_r;
    rec_off_nxt  = rec_off_r;
    rec_seg_nxt  = rec_seg_r;
    rec_ck_nxt   = rec_ck_r;
    seg_ck_nxt   = seg_ck_r;
    do_data_nxt  = do_data_r;
    do_eof_nxt   = do_eof_r;
    emit_ovf_nxt = emit_ovf_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = bidx_r[ADDR_W-1:0];
    char_c       = CHR_NL;
    rl_c         = 1'b0;
    done_c       = 1'b0;
    emit         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          // Overflow is reported on every character of this byte's records.
          emit_ovf_nxt = ovf_r || full_r;
          do_eof_nxt   = in_is_last;
          idx_nxt      = '0;
          bidx_nxt     = '0;
          if (full_r) begin
            // Address space exhausted: the byte is dropped.
            ovf_nxt     = 1'b1;
            do_data_nxt = 1'b0;
            state_nxt   = in_is_last ? ST_EOF : ST_IDLE;
          end else begin
            ram_we      = 1'b1;
            rec_seg_nxt = seg_r;
            seg_ck_nxt  = seg_ck;
            rec_off_nxt = off_r;
            rec_cnt_nxt = fill_inc;
            rec_ck_nxt  = data_ck;
            do_data_nxt = close;
            csum_nxt    = csum_new;
            fill_nxt    = fill_inc;
            if (close) begin
              fill_nxt = '0;
              csum_nxt = '0;
              if (off_sum[16]) begin
                off_nxt = '0;
                if (seg_r == 16'hFFFF) begin
                  full_nxt = 1'b1;
                end else begin
                  seg_nxt = seg_r + 16'd1;
                end
              end else begin
                off_nxt = off_sum[15:0];
              end
            end
            if (seg_start) begin
              state_nxt = ST_SEG;
            end else if (close) begin
              state_nxt = ST_DHDR;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          // The end of an image puts the running state back to its start.
          if (in_is_last) begin
            fill_nxt = '0;
            off_nxt  = '0;
            seg_nxt  = '0;
            csum_nxt = '0;
            ovf_nxt  = 1'b0;
            full_nxt = 1'b0;
          end
        end
      end

      ST_SEG: begin
        case (idx_r) inside
          [4'd0:4'd8]: char_c = seg_prefix_char(idx_r);
          4'd9:        char_c = hex_char(rec_seg_r[15:12]);
          4'd10:       char_c = hex_char(rec_seg_r[11:8]);
          4'd11:       char_c = hex_char(rec_seg_r[7:4]);
          4'd12:       char_c = hex_char(rec_seg_r[3:0]);
          4'd13:       char_c = hex_char(seg_ck_r[7:4]);
          4'd14:       char_c = hex_char(seg_ck_r[3:0]);
          default:     char_c = CHR_NL;
        endcase
        if (emit_ok) begin
          emit    = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == SEG_LAST) begin
            idx_nxt = '0;
            rl_c    = !do_data_r && !do_eof_r;
            if (do_data_r) begin
              state_nxt = ST_DHDR;
            end else if (do_eof_r) begin
              state_nxt = ST_EOF;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      ST_DHDR: begin
        case (idx_r) inside
          4'd0:        char_c = CHR_COLON;
          4'd1:        char_c = hex_char(rec_cnt8[7:4]);
          4'd2:        char_c = hex_char(rec_cnt8[3:0]);
          4'd3:        char_c = hex_char(rec_off_r[15:12]);
          4'd4:        char_c = hex_char(rec_off_r[11:8]);
          4'd5:        char_c = hex_char(rec_off_r[7:4]);
          4'd6:        char_c = hex_char(rec_off_r[3:0]);
          default:     char_c = CHR_ZERO;
        endcase
        if (emit_ok) begin
          emit    = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == HDR_LAST) begin
            // Fetch the first data byte while the record type goes out.
            idx_nxt   = '0;
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_nxt = ST_DHI;
          end
        end
      end

      ST_DHI: begin
        char_c = hex_char(ram_rdata[7:4]);
        if (emit_ok) begin
          emit      = 1'b1;
          byte_nxt  = ram_rdata;
          // Prefetch the next byte; the read data holds until it is needed.
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(bidx_r + FILL_W'(1));
          state_nxt = ST_DLO;
        end
      end

      ST_DLO: begin
        char_c = hex_char(byte_r[3:0]);
        if (emit_ok) begin
          emit     = 1'b1;
          bidx_nxt = bidx_r + FILL_W'(1);
          if ((bidx_r + FILL_W'(1)) == rec_cnt_r) begin
            state_nxt = ST_DTAIL;
          end else begin
            state_nxt = ST_DHI;
          end
        end
      end

      ST_DTAIL: begin
        case (idx_r) inside
          4'd0:    char_c = hex_char(rec_ck_r[7:4]);
          4'd1:    char_c = hex_char(rec_ck_r[3:0]);
          default: char_c = CHR_NL;
        endcase
        if (emit_ok) begin
          emit    = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == TAIL_LAST) begin
            idx_nxt   = '0;
            rl_c      = !do_eof_r;
            state_nxt = do_eof_r ? ST_EOF : ST_IDLE;
          end
        end
      end

      ST_EOF: begin
        char_c = eof_char(idx_r);
        if (emit_ok) begin
          emit    = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_r == EOF_LAST) begin
            idx_nxt   = '0;
            rl_c      = 1'b1;
            done_c    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Output register: load on emit, clear once the character is taken.
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_rl_nxt    = out_rl_r;
    out_done_nxt  = out_done_r;
    out_ovf_nxt   = out_ovf_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = char_c;
      out_rl_nxt    = rl_c;
      out_done_nxt  = done_c;
      out_ovf_nxt   = emit_ovf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_run_last   = out_rl_r;
  assign out_image_done = out_done_r;
  assign out_overflow   = out_ovf_r;

endmodule

// File: sv/ihre_checker.sv
// ============================================================================
// ihre_checker
// Port-level checks of the Intel HEX record encoder, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module ihre_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_is_last,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ihre_pkg::CHAR_W-1:0]  out_ascii_char,
  input logic                         out_run_last,
  input logic                         out_image_done
);

  import ihre_pkg::*;

  // Reset leaves an empty output register and an open input.
  `IHRE_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

  // A held character does not change while the receiver stalls.
  `IHRE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_ascii_char), "stalled character changed")

  // The end of an image is a newline that closes the run of its byte.
  `IHRE_ASSERT(a_done_nl, out_valid && out_image_done |-> out_ascii_char == CHR_NL && out_run_last, "image end is not a final newline")

  // A last byte always yields the end-of-file record, so the input closes.
  `IHRE_ASSERT(a_last_busy, in_valid && !in_stall && in_is_last |=> in_stall, "last byte gave no records")

endmodule

bind intel_hex_record_encoder_unit ihre_checker u_ihre_checker (.*);

// File: tb/intel_hex_record_checker.sv
// ============================================================================
// intel_hex_record_checker
// Predicts the Intel HEX text of the encoder and checks every character.
// ============================================================================
// Watches both channels of the encoder. Each accepted input byte is run
// through a local model of the record encoder. The model queues the
// characters that the byte should produce. Each accepted output character is
// compared with the oldest queued one.
// ============================================================================
module intel_hex_record_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [ihre_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                        in_is_last,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [ihre_pkg::CHAR_W-1:0] out_ascii_char,
  input  logic                        out_run_last,
  input  logic                        out_image_done,
  input  logic                        out_overflow,
  output int                          error_count,
  output int                          chars_pending
);

  localparam int          RECORD_LEN   = ihre_pkg::REC_BYTES;
  localparam int unsigned SEGMENT_SIZE = 32'h1_0000;
  localparam int          MAX_REPORTS  = 10;

  localparam logic [7:0] COLON            = 8'h3A;
  localparam logic [7:0] NEWLINE          = 8'h0A;
  localparam logic [7:0] DIGIT_ZERO       = 8'h30;
  localparam logic [7:0] LETTER_A         = 8'h41;
  localparam logic [7:0] RECORD_TYPE_DATA = 8'h00;
  localparam logic [7:0] SEG_HEADER_SUM   = 8'h06;
  localparam string      SEG_HEADER_TEXT  = ":02000004";
  localparam string      EOF_TEXT         = ":00000001FF";

  typedef struct packed {
    logic [ihre_pkg::CHAR_W-1:0] ascii;
    logic                        run_last;
    logic                        image_done;
    logic                        overflow;
  } hex_char_t;

  hex_char_t   hex_text_q[$];
  int          chars_seen;

  logic [7:0]  rec_bytes [RECORD_LEN];
  int unsigned fill;
  int unsigned seg_offset;
  int unsigned seg_number;
  logic [7:0]  byte_sum;
  logic        dropped_seen;
  logic        addr_space_full;

  task automatic clear_image();
    fill            = 0;
    seg_offset      = 0;
    seg_number      = 0;
    byte_sum        = 8'h00;
    dropped_seen    = 1'b0;
    addr_space_full = 1'b0;
  endtask

  task automatic push_char(input logic [7:0] code, input logic done);
    hex_text_q.push_back('{ascii: code[ihre_pkg::CHAR_W-1:0], run_last: 1'b0,
                           image_done: done, overflow: dropped_seen});
  endtask

  task automatic push_hex(input logic [7:0] value);
    logic [3:0] nib;
    for (int k = 1; k >= 0; k--) begin
      nib = value[k*4 +: 4];
      push_char((nib < 4'd10) ? DIGIT_ZERO + 8'(nib) : LETTER_A + 8'(nib) - 8'd10, 1'b0);
    end
  endtask

  task automatic push_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      push_char(text[i], 1'b0);
    end
  endtask

  task automatic push_segment_record();
    logic [7:0] hi, lo;
    hi = 8'(seg_number >> 8);
    lo = 8'(seg_number);
    push_text(SEG_HEADER_TEXT);
    push_hex(hi);
    push_hex(lo);
    push_hex(8'd0 - (SEG_HEADER_SUM + hi + lo));
    push_char(NEWLINE, 1'b0);
  endtask

  task automatic push_data_record();
    logic [7:0] hi, lo, sum;
    hi  = 8'(seg_offset >> 8);
    lo  = 8'(seg_offset);
    sum = 8'(fill) + hi + lo + byte_sum;
    push_char(COLON, 1'b0);
    push_hex(8'(fill));
    push_hex(hi);
    push_hex(lo);
    push_hex(RECORD_TYPE_DATA);
    for (int i = 0; i < int'(fill) && i < RECORD_LEN; i++) begin
      push_hex(rec_bytes[i]);
    end
    push_hex(8'd0 - sum);
    push_char(NEWLINE, 1'b0);
  endtask

  // Queues every character that one accepted image byte should produce.
  task automatic encode_byte(input logic [7:0] value, input logic last);
    int start_size;
    start_size = hex_text_q.size();
    if (addr_space_full) begin
      dropped_seen = 1'b1;
    end else begin
      if (fill == 0 && seg_offset == 0) begin
        push_segment_record();
      end
      if (fill < RECORD_LEN) begin
        rec_bytes[fill] = value;
      end
      byte_sum = byte_sum + value;
      fill++;
      if (fill >= RECORD_LEN || seg_offset + fill >= SEGMENT_SIZE || last) begin
        push_data_record();
        seg_offset += fill;
        fill     = 0;
        byte_sum = 8'h00;
        if (seg_offset >= SEGMENT_SIZE) begin
          seg_offset = 0;
          if (seg_number >= 32'hFFFF) begin
            addr_space_full = 1'b1;
          end else begin
            seg_number++;
          end
        end
      end
    end
    if (last) begin
      push_text(EOF_TEXT);
      push_char(NEWLINE, 1'b1);
      clear_image();
    end
    if (hex_text_q.size() > start_size) begin
      hex_text_q[hex_text_q.size()-1].run_last = 1'b1;
    end
  endtask

  task automatic check_char(input hex_char_t got);
    hex_char_t want;
    if (hex_text_q.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("ERROR: char %0d unexpected: ascii=%h run_last=%b done=%b ovf=%b",
                 chars_seen, got.ascii, got.run_last, got.image_done, got.overflow);
      end
    end else begin
      want = hex_text_q.pop_front();
      if (got.ascii !== want.ascii || got.run_last !== want.run_last ||
          got.image_done !== want.image_done || got.overflow !== want.overflow) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("ERROR: char %0d expected ascii=%h run_last=%b done=%b ovf=%b",
                   chars_seen, want.ascii, want.run_last, want.image_done, want.overflow);
          $display("ERROR: char %0d actual   ascii=%h run_last=%b done=%b ovf=%b",
                   chars_seen, got.ascii, got.run_last, got.image_done, got.overflow);
        end
      end
    end
    chars_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_image();
      hex_text_q.delete();
      chars_seen  = 0;
      error_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(in_data_byte, in_is_last);
      end
      if (out_valid && !out_stall) begin
        check_char('{ascii: out_ascii_char, run_last: out_run_last,
                     image_done: out_image_done, overflow: out_overflow});
      end
    end
    chars_pending = hex_text_q.size();
  end

endmodule

// File: tb/intel_hex_record_encoder_unit_test.sv
// ============================================================================
// intel_hex_record_encoder_unit_test
// Stimulus and verdict for the Intel HEX record encoder.
// ============================================================================
// Feeds byte images into the encoder, first a handful of directed images and
// then randomly sized ones. A checker instance beside the encoder predicts
// the record text and compares every character; this module only drives the
// channels and reports the outcome.
// ============================================================================
module intel_hex_record_encoder_unit_test;

  // Rough number of bytes in the random small images.
  localparam int RANDOM_BYTES   = 180;
  localparam int DRAIN_CYCLES   = 16;
  // Far beyond the slowest correct run.
  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int IDLE_PCT       = 11;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [ihre_pkg::BYTE_W-1:0] in_data_byte;
  logic                        in_is_last;
  logic                        out_valid;
  logic                        out_stall;
  logic [ihre_pkg::CHAR_W-1:0] out_ascii_char;
  logic                        out_run_last;
  logic                        out_image_done;
  logic                        out_overflow;

  int error_count;
  int chars_pending;

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls. Both drop to zero for one stretch of the random part.
  int send_idle_pct;
  int recv_stall_pct;

  intel_hex_record_encoder_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_run_last   (out_run_last),
    .out_image_done (out_image_done),
    .out_overflow   (out_overflow)
  );

  intel_hex_record_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char),
    .out_run_last   (out_run_last),
    .out_image_done (out_image_done),
    .out_overflow   (out_overflow),
    .error_count    (error_count),
    .chars_pending  (chars_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver stalls at random. A stall only holds the current character
  // in place, so it may change on any cycle.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one byte and returns at the clock edge where it was transferred.
  // The sender may first hold back at random. The payload stays put
  // while the encoder stalls, and in_valid is left high on return so that a
  // following byte can go out back to back.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= value;
    in_is_last   <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Sends one image of random bytes; only the final byte is flagged last.
  task automatic send_random_image(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // Stops offering bytes until the checker holds no outstanding characters.
  task automatic wait_for_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    int bytes_sent;
    int image_idx;
    int len;

    send_idle_pct  = IDLE_PCT;
    recv_stall_pct = IDLE_PCT;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= '0;
    in_is_last   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed images. The two one-byte images carry the smallest and the
    // largest byte value, each giving a segment record, a one-byte data
    // record and the end-of-file record.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // The sender holds back until all text of the first images is out.
    wait_for_text();
    // A full record whose final byte is also the last of the image, with
    // bytes 00, 11, ... FF so that every hex digit shows up in both places.
    for (int i = 0; i < 16; i++) begin
      send_byte(8'(i * 8'h11), i == 15);
    end
    // A short image whose bytes toggle the top and bottom bits.
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);

    // Random images. Most lengths are small and arbitrary; about a quarter
    // are multiples of the record size or one byte more, so that a record
    // fills exactly at the last byte or just before it.
    bytes_sent = 0;
    image_idx  = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if ($urandom_range(3) == 0) begin
        len = 16 * $urandom_range(1, 3) + $urandom_range(1) * $urandom_range(1);
      end else begin
        len = $urandom_range(1, 40);
      end
      // Images two to four run without any idling on either side.
      if (image_idx == 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (image_idx == 5) begin
        send_idle_pct  = IDLE_PCT;
        recv_stall_pct = IDLE_PCT;
      end
      send_random_image(len);
      bytes_sent += len;
      if (image_idx == 6) begin
        wait_for_text();
      end
      image_idx++;
    end

    // Wait for the last characters, then keep clocking the encoder for a drain
    // period in which any stray character would still be caught.
    wait_for_text();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && chars_pending == 0) begin
      $display("intel_hex_record_encoder_unit: match");
    end else begin
      $display("intel_hex_record_encoder_unit: mismatch");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(64'(TIMEOUT_CYCLES) * 10);
    $display("intel_hex_record_encoder_unit: mismatch");
    $finish;
  end

endmodule
